[src/positional_list_engine_top_assert.svh]
// assertion macros used by the port-level checker file
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PLE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ple_pkg.sv]
// shared types, codes and defaults of the positional list engine
package ple_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_POP    = 2'd2,
        CMD_READ   = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // what every cell of the row does on a given cycle
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_INSERT,
        OP_POP
    } cell_op_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic signed [7:0] position;
        logic [31:0]       data_in;
    } cmd_beat_t;

    typedef struct packed {
        logic [31:0] data_out;
        logic [1:0]  status;
        logic [6:0]  entry_count;
    } rsp_beat_t;

endpackage

[src/ple_chan_if.sv]
// valid/ready channel carrying one beat of a given payload type
interface ple_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/ple_cell.sv]
// one list slot: holds a word and shifts with its neighbors
module ple_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IW         = 6,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  ple_pkg::cell_op_t     op,
    input  logic [IW-1:0]         idx,
    input  logic [DATA_WIDTH-1:0] word,
    input  logic [DATA_WIDTH-1:0] left,
    input  logic [DATA_WIDTH-1:0] right,
    output logic [DATA_WIDTH-1:0] entry,
    output logic [DATA_WIDTH-1:0] tap
);
    import ple_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (op)
            OP_LOAD:
            begin
                if (idx == MY_IDX)
                    entry_next = word;
            end
            OP_INSERT:
            begin
                if (idx == MY_IDX)
                    entry_next = word;
                else if (MY_IDX > idx)
                    entry_next = left;
            end
            OP_POP:
            begin
                if (MY_IDX >= idx)
                    entry_next = right;
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    // gated copy for the read-out or-tree
    assign tap   = (idx == MY_IDX) ? entry_reg : '0;
endmodule

[src/ple_ctrl.sv]
// command decode, entry count and registered response beat
module ple_ctrl #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32,
    parameter int IW         = 6,
    parameter int CW         = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    ple_chan_if.sink              cmd_ch,
    ple_chan_if.source            rsp_ch,
    input  logic [DATA_WIDTH-1:0] rd_word,
    output ple_pkg::cell_op_t     cell_op,
    output logic [IW-1:0]         cell_idx,
    output logic [DATA_WIDTH-1:0] cell_word
);
    import ple_pkg::*;

    localparam int SW = CW + 9;
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                state_reg, state_next;
    cell_op_t              op_reg, op_next;
    logic [IW-1:0]         idx_reg, idx_next;
    status_t               status_reg, status_next;
    logic [DATA_WIDTH-1:0] word_reg, word_next;
    logic                  fetch_reg, fetch_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [31:0]           rsp_data_reg, rsp_data_next;
    status_t               rsp_status_reg, rsp_status_next;
    logic [6:0]            rsp_count_reg, rsp_count_next;

    logic                   accept;
    logic                   fire;
    logic signed [SW-1:0]   n_s;
    logic signed [SW-1:0]   pos_s;
    logic signed [SW-1:0]   abs_idx;
    logic [DATA_WIDTH+31:0] din_wide;
    logic [DATA_WIDTH+31:0] dout_wide;
    logic [CW+6:0]          cnt_wide;
    cmd_beat_t              beat;

    assign beat     = cmd_ch.payload;
    assign accept   = cmd_ch.valid && cmd_ch.ready;
    assign fire     = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ch.ready);
    assign n_s      = SW'(signed'({1'b0, count_reg}));
    assign pos_s    = SW'(beat.position);
    assign abs_idx  = (pos_s < 0) ? (n_s + pos_s) : pos_s;
    assign din_wide = (DATA_WIDTH + 32)'(beat.data_in);
    assign dout_wide = (DATA_WIDTH + 32)'(rd_word);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        status_next     = status_reg;
        word_next       = word_reg;
        fetch_next      = fetch_reg;
        count_next      = count_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_data_next   = rsp_data_reg;
        rsp_status_next = rsp_status_reg;
        rsp_count_next  = rsp_count_reg;
        cnt_wide        = '0;

        if (rsp_valid_reg && rsp_ch.ready)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next  = S_EXEC;
                    word_next   = din_wide[DATA_WIDTH-1:0];
                    op_next     = OP_HOLD;
                    fetch_next  = 1'b0;
                    status_next = ST_OK;
                    idx_next    = abs_idx[IW-1:0];
                    unique case (beat.cmd) inside
                        CMD_APPEND:
                        begin
                            idx_next = count_reg[IW-1:0];
                            if (count_reg == FULL_COUNT)
                                status_next = ST_FULL;
                            else
                                op_next = OP_LOAD;
                        end
                        CMD_INSERT:
                        begin
                            if (pos_s < 0 || pos_s > n_s)
                                status_next = ST_BADPOS;
                            else if (count_reg == FULL_COUNT)
                                status_next = ST_FULL;
                            else
                                op_next = OP_INSERT;
                        end
                        CMD_POP, CMD_READ:
                        begin
                            if (pos_s >= n_s || pos_s < -n_s)
                                status_next = ST_RANGE;
                            else
                            begin
                                fetch_next = 1'b1;
                                if (beat.cmd == CMD_POP)
                                    op_next = OP_POP;
                            end
                        end
                        default: status_next = ST_RANGE;
                    endcase
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                    case (op_reg) inside
                        OP_LOAD, OP_INSERT: count_next = count_reg + 1'b1;
                        OP_POP:             count_next = count_reg - 1'b1;
                        default:            count_next = count_reg;
                    endcase
                    cnt_wide        = (CW + 7)'(count_next);
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_count_next  = cnt_wide[6:0];
                    rsp_data_next   = fetch_reg ? dout_wide[31:0] : 32'd0;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_HOLD;
            idx_reg        <= '0;
            status_reg     <= ST_OK;
            word_reg       <= '0;
            fetch_reg      <= 1'b0;
            count_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_data_reg   <= '0;
            rsp_status_reg <= ST_OK;
            rsp_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            idx_reg        <= idx_next;
            status_reg     <= status_next;
            word_reg       <= word_next;
            fetch_reg      <= fetch_next;
            count_reg      <= count_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_data_reg   <= rsp_data_next;
            rsp_status_reg <= rsp_status_next;
            rsp_count_reg  <= rsp_count_next;
        end
    end

    assign cmd_ch.ready = (state_reg == S_IDLE);

    assign rsp_ch.valid               = rsp_valid_reg;
    assign rsp_ch.payload.data_out    = rsp_data_reg;
    assign rsp_ch.payload.status      = rsp_status_reg;
    assign rsp_ch.payload.entry_count = rsp_count_reg;

    // the row moves only on the cycle the command executes
    assign cell_op   = fire ? op_reg : OP_HOLD;
    assign cell_idx  = idx_reg;
    assign cell_word = word_reg;
endmodule

[src/positional_list_engine_top.sv]
// positional list engine: top level with the command decoder and the row of list cells
//
// An ordered list of up to CAPACITY words of DATA_WIDTH bits. Each command beat
// on cmd_ch appends, inserts at a position, pops at a position or reads at a
// position; pop and read take negative positions counting back from the end.
// Every command gives exactly one response beat on rsp_ch with the popped or
// read word (zero otherwise), a status code and the entry count afterwards.
// Timing: a command is taken when the engine is idle, decoded into a register
// in that cycle, and executed in S_EXEC once the output register is free; the
// whole row of cells then shifts in parallel and the response is written into
// the output register. A command therefore occupies the engine through S_IDLE
// and S_EXEC, and waits in S_EXEC while an earlier response still sits unread
// in the output register; the decode register ahead of the cell row sets this.
// A new command may be taken while the previous response is still waiting.
// After reset the list is empty; the cell words are not cleared, as no slot
// at or beyond the entry count is ever returned, so no clearing pass is run.
module positional_list_engine_top #(
    parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ple_chan_if.sink   cmd_ch,
    ple_chan_if.source rsp_ch
);
    import ple_pkg::*;

    // slot index and count widths
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // broadcast control from the decoder to every cell
    cell_op_t              cell_op;
    logic [IW-1:0]         cell_idx;
    logic [DATA_WIDTH-1:0] cell_word;

    // stored words and the per-cell gated read taps
    logic [DATA_WIDTH-1:0] entry [CAPACITY];
    logic [DATA_WIDTH-1:0] tap   [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_word;

    ple_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .IW         (IW),
        .CW         (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ch    (cmd_ch),
        .rsp_ch    (rsp_ch),
        .rd_word   (rd_word),
        .cell_op   (cell_op),
        .cell_idx  (cell_idx),
        .cell_word (cell_word)
    );

    // row of cells: on insert each one above the position takes from its left
    // neighbor, on pop each one at or above it from its right neighbor, all at once
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = entry[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = entry[g+1];
        end

        ple_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IW         (IW),
            .INDEX      (g)
        ) u_cell (
            .clk   (clk),
            .op    (cell_op),
            .idx   (cell_idx),
            .word  (cell_word),
            .left  (left_w),
            .right (right_w),
            .entry (entry[g]),
            .tap   (tap[g])
        );
    end

    // only the addressed cell drives a nonzero tap, so an or over the row
    // picks out the word being popped or read
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_word = rd_word | tap[i];
    end
endmodule

[src/ple_checker.sv]
// port-level checks of the positional list engine and their binding
`include "positional_list_engine_top_assert.svh"

module ple_checker #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input ple_pkg::rsp_beat_t rsp_payload
);
    import ple_pkg::*;

    logic cmd_fire;
    logic rsp_stall;
    logic rsp_err;
    logic rsp_full;
    logic err_data_zero;
    logic full_count_ok;

    assign cmd_fire      = cmd_valid && cmd_ready;
    assign rsp_stall     = rsp_valid && !rsp_ready;
    assign rsp_err       = rsp_valid && (rsp_payload.status != ST_OK);
    assign rsp_full      = rsp_valid && (rsp_payload.status == ST_FULL);
    assign err_data_zero = (rsp_payload.data_out == 32'd0);
    assign full_count_ok = (rsp_payload.entry_count == 7'(CAPACITY));

    `PLE_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "stalled beat changed")
    `PLE_ASSERT_NEXT(a_one_cmd, cmd_fire, !cmd_ready, "command taken while busy")
    `PLE_ASSERT_SAME(a_err_zero, rsp_err, err_data_zero, "data on an error beat")
    `PLE_ASSERT_SAME(a_full_cnt, rsp_full, full_count_ok, "full status below capacity")
endmodule

bind positional_list_engine_top ple_checker #(
    .CAPACITY (CAPACITY)
) u_ple_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_ch.valid),
    .cmd_ready   (cmd_ch.ready),
    .rsp_valid   (rsp_ch.valid),
    .rsp_ready   (rsp_ch.ready),
    .rsp_payload (rsp_ch.payload)
);

[verif/testbench.sv]
// self-checking testbench for positional_list_engine_top: directed and random command beats
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 300000;
    // idle cycles at the end for the final quiet check
    localparam int TAIL_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ple_chan_if #(.payload_t(cmd_beat_t)) cmd_ch ();
    ple_chan_if #(.payload_t(rsp_beat_t)) rsp_ch ();

    positional_list_engine_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch),
        .rsp_ch (rsp_ch)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // command beats waiting to be offered, responses waiting to be seen
    cmd_beat_t pending_cmds[$];
    rsp_beat_t expected_rsps[$];

    // list contents as the engine should hold them
    logic [31:0] list_words[CAPACITY];
    int          list_len = 0;

    // entry count as the generator expects it, used to aim positions
    int plan_len = 0;

    // idling controls, set per phase by the stimulus process
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // long receiver hold-off requests, served by the ready process
    int holdoff_requests = 0;
    int holdoff_served   = 0;
    int holdoff_left     = 0;

    // bookkeeping
    bit cmd_taken  = 1'b0;
    int error_count = 0;
    int cycle_count = 0;
    int beats_in    = 0;
    int beats_out   = 0;
    int peak_len    = 0;
    int status_seen[4] = '{default: 0};

    // ------------------------------------------------------------------
    // predictor: applies one command to the local copy of the list
    // ------------------------------------------------------------------
    function automatic rsp_beat_t apply_command(cmd_beat_t beat);
        rsp_beat_t rsp;
        int        pos;
        int        slot;
        rsp = '0;
        pos = beat.position;
        case (cmd_code_t'(beat.cmd))
            CMD_APPEND:
            begin
                if (list_len >= CAPACITY)
                begin
                    rsp.status = ST_FULL;
                end
                else
                begin
                    list_words[list_len] = beat.data_in;
                    list_len++;
                    rsp.status = ST_OK;
                end
            end
            CMD_INSERT:
            begin
                // a bad position wins over a full list
                if (pos < 0 || pos > list_len)
                begin
                    rsp.status = ST_BADPOS;
                end
                else if (list_len >= CAPACITY)
                begin
                    rsp.status = ST_FULL;
                end
                else
                begin
                    for (int i = list_len; i > pos; i--)
                    begin
                        list_words[i] = list_words[i - 1];
                    end
                    list_words[pos] = beat.data_in;
                    list_len++;
                    rsp.status = ST_OK;
                end
            end
            default:
            begin
                // pop and read share the range check and the negative index fold
                if (pos >= list_len || pos < -list_len)
                begin
                    rsp.status = ST_RANGE;
                end
                else
                begin
                    slot = (pos < 0) ? list_len + pos : pos;
                    rsp.data_out = list_words[slot];
                    rsp.status   = ST_OK;
                    if (cmd_code_t'(beat.cmd) == CMD_POP)
                    begin
                        for (int i = slot; i + 1 < list_len; i++)
                        begin
                            list_words[i] = list_words[i + 1];
                        end
                        list_len--;
                    end
                end
            end
        endcase
        rsp.entry_count = list_len[6:0];
        return rsp;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("[%0t] mismatch on %s after %0d responses: got 0x%0h, expected 0x%0h",
                 $realtime, what, beats_out, got, want);
    endtask

    // ------------------------------------------------------------------
    // monitor: sample at the rising edge, check responses before
    // recording the command accepted on the same edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_beat_t got;
        rsp_beat_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses still expected",
                     cycle_count, expected_rsps.size());
            $display("FAILURE");
            $finish;
        end
        else if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = rsp_ch.payload;
                beats_out++;
                status_seen[got.status]++;
                if (expected_rsps.size() == 0)
                begin
                    report_mismatch("unexpected response beat", got.data_out, 32'd0);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (got.data_out !== want.data_out)
                        report_mismatch("data_out", got.data_out, want.data_out);
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 32'(got.entry_count),
                                        32'(want.entry_count));
                end
            end
            cmd_taken = cmd_ch.valid && cmd_ch.ready;
            if (cmd_taken)
            begin
                beats_in++;
                expected_rsps.push_back(apply_command(cmd_ch.payload));
                if (list_len > peak_len)
                    peak_len = list_len;
            end
        end
    end

    // ------------------------------------------------------------------
    // driver: offers the next pending command on the falling edge once
    // the slot is free, idling at the phase's rate
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        bit offer;
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
        end
        else if (!cmd_ch.valid || cmd_taken)
        begin
            offer = (pending_cmds.size() > 0) &&
                    ($urandom_range(99) >= send_idle_pct);
            if (offer)
            begin
                cmd_ch.payload <= pending_cmds.pop_front();
                cmd_ch.valid   <= 1'b1;
            end
            else
            begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, plus a long hold-off counted here
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (holdoff_served != holdoff_requests)
        begin
            holdoff_served++;
            holdoff_left = 300;
            rsp_ch.ready <= 1'b0;
        end
        else if (holdoff_left > 0)
        begin
            holdoff_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // queue a command and track the entry count it should leave behind
    task automatic queue_command(cmd_code_t op, int pos, logic [31:0] word);
        cmd_beat_t beat;
        beat.cmd      = op;
        beat.position = pos[7:0];
        beat.data_in  = word;
        pending_cmds.push_back(beat);
        case (op)
            CMD_APPEND:
                if (plan_len < CAPACITY)
                    plan_len++;
            CMD_INSERT:
                if (pos >= 0 && pos <= plan_len && plan_len < CAPACITY)
                    plan_len++;
            CMD_POP:
                if (pos < plan_len && pos >= -plan_len)
                    plan_len--;
            default:
                ;
        endcase
    endtask

    // mostly valid positions at the edges and inside, some random from -64 to 64
    function automatic int pick_position(cmd_code_t op);
        int top;
        top = (op == CMD_INSERT) ? plan_len : plan_len - 1;
        if (top < 0)
            return int'($urandom_range(128)) - 64;
        case ($urandom_range(9))
            0: return 0;
            1: return top;
            2: return (op == CMD_INSERT) ? top : -plan_len;
            3: return (op == CMD_INSERT) ? top + 1 : -1;
            4, 5: return int'($urandom_range(top, 0));
            6: return (plan_len > 0) ? -int'($urandom_range(plan_len, 1)) : 0;
            default: return int'($urandom_range(128)) - 64;
        endcase
    endfunction

    // waves of growth and shrinkage so the list visits empty and full often
    bit growing = 1'b1;

    task automatic random_burst(int n);
        cmd_code_t op;
        int        roll;
        repeat (n)
        begin
            if (plan_len >= CAPACITY && $urandom_range(5) == 0)
                growing = 1'b0;
            else if (plan_len == 0 && $urandom_range(3) == 0)
                growing = 1'b1;
            else if ($urandom_range(39) == 0)
                growing = !growing;
            roll = $urandom_range(99);
            if (growing)
                op = (roll < 45) ? CMD_APPEND : (roll < 80) ? CMD_INSERT :
                     (roll < 90) ? CMD_POP : CMD_READ;
            else
                op = (roll < 10) ? CMD_APPEND : (roll < 20) ? CMD_INSERT :
                     (roll < 65) ? CMD_POP : CMD_READ;
            queue_command(op, pick_position(op), $urandom());
        end
    endtask

    // sender holds back until every expected response is in
    task automatic wait_for_drain();
        while (pending_cmds.size() > 0 || cmd_ch.valid || expected_rsps.size() > 0)
            @(negedge clk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        rsp_ch.ready   = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty-list errors, bad insert positions, ignored fields,
        // negative positions at both ends, insert at the end
        set_idling(0, 0);
        queue_command(CMD_POP,     0,   32'hDEAD_BEEF);
        queue_command(CMD_READ,   -1,   32'h0);
        queue_command(CMD_INSERT,  1,   32'h1111_1111);
        queue_command(CMD_INSERT, -1,   32'h2222_2222);
        queue_command(CMD_APPEND,  64,  32'hFFFF_FFFF);
        queue_command(CMD_APPEND, -64,  32'h0000_0000);
        queue_command(CMD_INSERT,  0,   32'hA5A5_A5A5);
        queue_command(CMD_INSERT,  3,   32'h5A5A_5A5A);
        queue_command(CMD_INSERT,  5,   32'h3333_3333);
        queue_command(CMD_READ,    0,   32'hFFFF_FFFF);
        queue_command(CMD_READ,   -1,   32'h0);
        queue_command(CMD_READ,   -4,   32'h0);
        queue_command(CMD_READ,    4,   32'h0);
        queue_command(CMD_READ,   -5,   32'h0);
        queue_command(CMD_POP,     1,   32'hFFFF_FFFF);
        queue_command(CMD_POP,    -1,   32'h0);
        queue_command(CMD_POP,    -2,   32'h0);
        queue_command(CMD_POP,     0,   32'h0);
        queue_command(CMD_POP,    -1,   32'h0);
        queue_command(CMD_READ,    64,  32'h0);
        queue_command(CMD_READ,   -64,  32'h0);
        wait_for_drain();

        // random waves under each idling mix
        set_idling(0, 0);
        random_burst(250);
        wait_for_drain();

        set_idling(58, 0);
        random_burst(250);
        wait_for_drain();

        set_idling(0, 58);
        random_burst(250);
        wait_for_drain();

        set_idling(31, 31);
        random_burst(250);
        wait_for_drain();

        // long receiver hold-off while the sender keeps offering, so the
        // engine backs up and stalls its command side
        set_idling(0, 0);
        holdoff_requests++;
        random_burst(60);
        wait_for_drain();

        // quiet tail: anything arriving now is an extra response
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("covered %0d commands and %0d responses, peak fill %0d of %0d",
                 beats_in, beats_out, peak_len, CAPACITY);
        $display("statuses seen: ok %0d, out of range %0d, bad insert %0d, full %0d",
                 status_seen[ST_OK], status_seen[ST_RANGE],
                 status_seen[ST_BADPOS], status_seen[ST_FULL]);
        if (error_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("%0d mismatches", error_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[positional_list_engine_top.f]
+incdir+src
src/ple_pkg.sv
src/ple_chan_if.sv
src/ple_cell.sv
src/ple_ctrl.sv
src/positional_list_engine_top.sv
src/ple_checker.sv
verif/testbench.sv
